FILE: rtl/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared sizes, opcodes, word format and the star-closure function of the
// multi-pattern wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpwm_pkg;

  localparam int unsigned MAX_PATTERNS    = 8;
  localparam int unsigned MAX_PATTERN_LEN = 32;

  localparam int unsigned SLOT_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned POS_W  = $clog2(MAX_PATTERN_LEN);
  localparam int unsigned LCNT_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned ACT_W  = MAX_PATTERN_LEN + 1;

  localparam logic [7:0] STAR_CH = 8'd42;
  localparam logic [7:0] ANY_CH  = 8'd63;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PAT   = 2'd1,
    OP_ADDR  = 2'd2,
    OP_END   = 2'd3
  } op_e;

  typedef logic [ACT_W-1:0] act_t;

  typedef struct packed {
    logic              vld;
    op_e               op;
    logic [7:0]        ch;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              wr;
    logic              commit;
    logic              err;
    logic              match;
  } word_t;

  typedef struct packed {
    logic             err;
    logic [CNT_W-1:0] cnt;
  } stat_t;

  // Spread active bits through runs of '*' positions with one carry chain.
  function automatic act_t star_closure(act_t v, act_t s);
    act_t g;
    g = v & s;
    return v | ((s + g) ^ s ^ g);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mpwm_head.sv
// ----------------------------------------------------------------------------
// mpwm_head
// Load bookkeeping: pattern count, load position, drop and error flags.
// Tags each accepted word with its target slot and position for the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_head (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  logic [1:0]      op_i,
  input  logic [7:0]      ch_i,
  input  logic            last_i,
  output mpwm_pkg::word_t word_o,
  output mpwm_pkg::stat_t stat_o
);
  import mpwm_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LCNT_W-1:0] lpos_q, lpos_d;
  logic              drop_q, drop_d;
  logic              err_q, err_d;
  word_t             word_q, word_d;
  op_e               op;
  logic              full, too_long, wr, drop_now;

  always_comb begin
    op       = op_e'(op_i);
    full     = cnt_q >= CNT_W'(MAX_PATTERNS);
    too_long = lpos_q >= LCNT_W'(MAX_PATTERN_LEN);
    wr       = !full && !too_long;
    drop_now = drop_q || !wr;

    word_d.vld    = in_valid_i;
    word_d.op     = op;
    word_d.ch     = ch_i;
    word_d.last   = last_i;
    word_d.slot   = cnt_q[SLOT_W-1:0];
    word_d.pos    = lpos_q[POS_W-1:0];
    word_d.wr     = wr;
    word_d.commit = last_i && !drop_now;
    word_d.err    = err_q;
    word_d.match  = 1'b0;

    cnt_d  = cnt_q;
    lpos_d = lpos_q;
    drop_d = drop_q;
    err_d  = err_q;
    if (in_valid_i) begin
      unique case (op)
        OP_CLEAR: begin
          cnt_d  = '0;
          lpos_d = '0;
          drop_d = 1'b0;
        end
        OP_PAT: begin
          if (wr) begin
            lpos_d = lpos_q + LCNT_W'(1);
          end
          drop_d = drop_now;
          if (last_i) begin
            if (drop_now) begin
              err_d = 1'b1;
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
            lpos_d = '0;
            drop_d = 1'b0;
          end
        end
        OP_ADDR, OP_END: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lpos_q <= '0;
      drop_q <= 1'b0;
      err_q  <= 1'b0;
      word_q <= '0;
    end else if (en_i) begin
      cnt_q  <= cnt_d;
      lpos_q <= lpos_d;
      drop_q <= drop_d;
      err_q  <= err_d;
      word_q <= word_d;
    end
  end

  assign word_o = word_q;
  assign stat_o = '{err: err_q, cnt: cnt_q};

endmodule

`default_nettype wire

FILE: rtl/mpwm_cell.sv
// ----------------------------------------------------------------------------
// mpwm_cell
// One pattern slot: stores the pattern bytes and its active-position vector,
// advances the vector on address bytes and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mpwm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [mpwm_pkg::SLOT_W-1:0] idx_i,
  input  mpwm_pkg::word_t             word_i,
  output mpwm_pkg::word_t             word_o
);
  import mpwm_pkg::*;

  localparam int unsigned LEN = MAX_PATTERN_LEN;

  logic [7:0]     pat_q [LEN];
  logic [LEN-1:0] star_q, star_d, any_q, any_d, used_q, used_d, hit_mask;
  logic           com_q, com_d;
  act_t           act_q, act_d;
  word_t          word_q, word_d;
  logic           wr_here, commit_here;
  act_t           star_ext, star_ext_d, accept_mask, step_v, adv_v, start_v, start_new_v;

  always_comb begin
    wr_here     = word_i.vld && (word_i.op == OP_PAT) && word_i.wr && (word_i.slot == idx_i);
    commit_here = wr_here && word_i.commit;

    for (int i = 0; i < LEN; i++) begin
      hit_mask[i] = used_q[i] & (star_q[i] | any_q[i] | (pat_q[i] == word_i.ch));
      if (wr_here && (word_i.pos == POS_W'(i))) begin
        star_d[i] = word_i.ch == STAR_CH;
        any_d[i]  = word_i.ch == ANY_CH;
        used_d[i] = 1'b1;
      end else if (wr_here && (word_i.pos == '0)) begin
        star_d[i] = 1'b0;
        any_d[i]  = 1'b0;
        used_d[i] = 1'b0;
      end else begin
        star_d[i] = star_q[i];
        any_d[i]  = any_q[i];
        used_d[i] = used_q[i];
      end
    end

    star_ext    = {1'b0, star_q};
    star_ext_d  = {1'b0, star_d};
    accept_mask = {used_q, 1'b1} & ~{1'b0, used_q};
    step_v      = {1'b0, act_q[LEN-1:0] & star_q} | {act_q[LEN-1:0] & hit_mask, 1'b0};
    adv_v       = star_closure(step_v, star_ext);
    start_v     = star_closure(ACT_W'(1), star_ext);
    start_new_v = star_closure(ACT_W'(1), star_ext_d);

    com_d  = com_q;
    act_d  = act_q;
    word_d = word_i;
    if (word_i.vld) begin
      unique case (word_i.op)
        OP_CLEAR: begin
          com_d = 1'b0;
          act_d = '0;
        end
        OP_PAT: begin
          if (commit_here) begin
            com_d = 1'b1;
            act_d = start_new_v;
          end
        end
        OP_ADDR: begin
          if (com_q) begin
            word_d.match = word_i.match | (word_i.last & (|(adv_v & accept_mask)));
            act_d        = word_i.last ? start_v : adv_v;
          end
        end
        OP_END: begin
          if (com_q) begin
            word_d.match = word_i.match | (|(act_q & accept_mask));
            act_d        = start_v;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      com_q  <= 1'b0;
      act_q  <= '0;
      star_q <= '0;
      any_q  <= '0;
      used_q <= '0;
      word_q <= '0;
    end else if (en_i) begin
      com_q  <= com_d;
      act_q  <= act_d;
      star_q <= star_d;
      any_q  <= any_d;
      used_q <= used_d;
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_here) begin
      pat_q[word_i.pos] <= word_i.ch;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

FILE: rtl/multi_pattern_wildcard_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_wildcard_matcher_core
// Glob matcher over up to MAX_PATTERNS stored patterns ('*' any run, '?' any
// byte), built as a chain of one cell per pattern slot.
//
// Input channel (in_valid_i / in_stall_o): one word per op_i code: clear
// patterns, pattern byte, address byte, end of empty address. last_i ends a
// pattern or an address. Output channel (out_valid_o / out_stall_i): one
// word per finished address with matched_o and the sticky load_error_o.
// A word walks the chain one cell per cycle unless stalled; its result passes
// the head, each cell and the output register to out_valid_o. One word is
// accepted every cycle unless in_stall_o is raised; the per-cycle work in
// each cell: one byte compare per position, three pattern-length carry chains.
// Reset empties the table, clears the error flag and the pipeline.
// While out_valid_o is held by out_stall_i the whole chain holds and
// in_stall_o is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_wildcard_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       load_error_o
);
  import mpwm_pkg::*;

  word_t chain [MAX_PATTERNS+1];
  word_t tail;
  stat_t stat;
  logic  en, tail_res;
  logic  out_vld_q, matched_q, lerr_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  mpwm_head u_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .word_o     (chain[0]),
    .stat_o     (stat)
  );

  for (genvar k = 0; k < MAX_PATTERNS; k++) begin : g_cell
    mpwm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (SLOT_W'(k)),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  assign tail     = chain[MAX_PATTERNS];
  assign tail_res = tail.vld && ((tail.op == OP_END) || ((tail.op == OP_ADDR) && tail.last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= tail_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      matched_q <= tail.match;
      lerr_q    <= tail.err;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign matched_o    = matched_q;
  assign load_error_o = lerr_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt <= CNT_W'(MAX_PATTERNS))
    else $error("stored pattern count beyond table size");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.err |=> stat.err)
    else $error("load error flag fell");

  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(tail_res))
    else $error("output word without a finished address");

endmodule

`default_nettype wire
